[hw/rtl/word_mix_hash64_unit_assert.svh]
// ----------------------------------------------------------------------------
// word_mix_hash64_unit_assert.svh
// assertion macros used by the hash unit sequencer rtl, clocked on clk, reset rst
// ----------------------------------------------------------------------------
`ifndef WORD_MIX_HASH64_UNIT_ASSERT_SVH
`define WORD_MIX_HASH64_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// check a property on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/wmh_pkg.sv]
// ----------------------------------------------------------------------------
// wmh_pkg
// constants, datapath command codes and shared types of the word mix hash
// ----------------------------------------------------------------------------
`default_nettype none

package wmh_pkg;

  // mixing constants
  localparam logic [63:0] MIX_C1    = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MIX_C2    = 64'hC4CEB9FE1A85EC53;
  localparam logic [63:0] HASH_SEED = 64'h93681D6255313A99;
  localparam int          MIX_SHIFT = 33;

  // datapath operation codes
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NOP  = 4'd0;
  localparam dp_op_t OP_LOAD = 4'd1;  // take masked chunk, add byte count
  localparam dp_op_t OP_MUL0 = 4'd2;  // acc = lo*lo
  localparam dp_op_t OP_MUL1 = 4'd3;  // acc.hi += lo*hi
  localparam dp_op_t OP_MUL2 = 4'd4;  // acc.hi += hi*lo
  localparam dp_op_t OP_MIXK = 4'd5;  // opnd = h ^ xorshift(acc)
  localparam dp_op_t OP_SETH = 4'd6;  // h = xorshift(acc)
  localparam dp_op_t OP_FIN  = 4'd7;  // opnd = xorshift(h ^ total)
  localparam dp_op_t OP_DONE = 4'd8;  // result = xorshift(acc), reload seed, clear total

  // constant select for the multiplier
  localparam logic CSEL_C1 = 1'b0;
  localparam logic CSEL_C2 = 1'b1;

  typedef struct packed {
    dp_op_t op;
    logic   csel;
  } dp_cmd_t;

  typedef struct packed {
    logic chunk_empty;
  } dp_status_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/wmh_datapath.sv]
// ----------------------------------------------------------------------------
// wmh_datapath
// running hash, byte total, shared 32x32 multiplier and result register
// ----------------------------------------------------------------------------
`default_nettype none

module wmh_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wmh_pkg::dp_cmd_t   cmd,
  output wmh_pkg::dp_status_t     status,
  input  wire logic [63:0]        chunk_data,
  input  wire logic [3:0]         valid_bytes,
  output logic [63:0]             hash_value
);
  import wmh_pkg::*;

  logic [63:0] hash;
  logic [63:0] total;
  logic [63:0] opnd;
  logic [63:0] acc;

  logic [3:0]  count;
  logic [63:0] masked;
  logic [63:0] mconst;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // saturate the byte count and zero the bytes above it
  always_comb begin
    count = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (4'(i) < count) ? chunk_data[i*8 +: 8] : 8'h00;
    end
  end

  assign status.chunk_empty = (valid_bytes == 4'd0);

  // partial product select
  always_comb begin
    mconst = (cmd.csel == CSEL_C2) ? MIX_C2 : MIX_C1;
    mul_a  = opnd[31:0];
    mul_b  = mconst[31:0];
    case (cmd.op)
      OP_MUL1: mul_b = mconst[63:32];
      OP_MUL2: mul_a = opnd[63:32];
      default: ;
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash  <= HASH_SEED;
      total <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: total <= total + 64'(count);
        OP_SETH: hash  <= xorshift(acc);
        OP_DONE: begin
          hash  <= HASH_SEED;
          total <= '0;
        end
        default: ;
      endcase
    end
  end

  // operand, accumulator and result
  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      OP_LOAD: opnd <= masked;
      OP_MUL0: acc <= prod;
      OP_MUL1, OP_MUL2: acc[63:32] <= acc[63:32] + prod[31:0];
      OP_MIXK: opnd <= hash ^ xorshift(acc);
      OP_FIN:  opnd <= xorshift(hash ^ total);
      OP_DONE: hash_value <= xorshift(acc);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/wmh_ctrl.sv]
// ----------------------------------------------------------------------------
// wmh_ctrl
// sequencer for chunk mixing, finalization and the result handshake
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_mix_hash64_unit_assert.svh"

module wmh_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                chunk_valid,
  output logic                     chunk_stall,
  input  wire logic                last_chunk,
  output logic                     hash_valid,
  input  wire logic                hash_stall,
  input  wire wmh_pkg::dp_status_t status,
  output wmh_pkg::dp_cmd_t         cmd
);
  import wmh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1_0 = 4'd1;
  localparam logic [3:0] S_M1_1 = 4'd2;
  localparam logic [3:0] S_M1_2 = 4'd3;
  localparam logic [3:0] S_MIXK = 4'd4;
  localparam logic [3:0] S_M2_0 = 4'd5;
  localparam logic [3:0] S_M2_1 = 4'd6;
  localparam logic [3:0] S_M2_2 = 4'd7;
  localparam logic [3:0] S_SETH = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_M3_0 = 4'd10;
  localparam logic [3:0] S_M3_1 = 4'd11;
  localparam logic [3:0] S_M3_2 = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       last;
  logic       accept;
  logic       out_free;

  assign chunk_stall = (state != S_IDLE);
  assign accept      = chunk_valid && !chunk_stall;
  assign out_free    = !hash_valid || !hash_stall;

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    cmd.csel   = CSEL_C1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!status.chunk_empty) begin
            cmd.op     = OP_LOAD;
            state_next = S_M1_0;
          end else if (last_chunk) begin
            state_next = S_FIN;
          end
        end
      end
      S_M1_0: begin cmd.op = OP_MUL0; state_next = S_M1_1; end
      S_M1_1: begin cmd.op = OP_MUL1; state_next = S_M1_2; end
      S_M1_2: begin cmd.op = OP_MUL2; state_next = S_MIXK; end
      S_MIXK: begin cmd.op = OP_MIXK; state_next = S_M2_0; end
      S_M2_0: begin cmd.op = OP_MUL0; cmd.csel = CSEL_C2; state_next = S_M2_1; end
      S_M2_1: begin cmd.op = OP_MUL1; cmd.csel = CSEL_C2; state_next = S_M2_2; end
      S_M2_2: begin cmd.op = OP_MUL2; cmd.csel = CSEL_C2; state_next = S_SETH; end
      S_SETH: begin
        cmd.op     = OP_SETH;
        state_next = last ? S_FIN : S_IDLE;
      end
      S_FIN:  begin cmd.op = OP_FIN;  state_next = S_M3_0; end
      S_M3_0: begin cmd.op = OP_MUL0; state_next = S_M3_1; end
      S_M3_1: begin cmd.op = OP_MUL1; state_next = S_M3_2; end
      S_M3_2: begin cmd.op = OP_MUL2; state_next = S_DONE; end
      S_DONE: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.op     = OP_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, last flag and result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last       <= 1'b0;
      hash_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last <= last_chunk;
      end
      if (state == S_DONE && out_free) begin
        hash_valid <= 1'b1;
      end else if (!hash_stall) begin
        hash_valid <= 1'b0;
      end
    end
  end

  // a waiting result is never overwritten
  `ASSERT_CLK(a_done_holds, (state == S_DONE && hash_valid && hash_stall) |=> (state == S_DONE), "result overwritten while stalled")
  // a new result beat comes only from the final step
  `ASSERT_CLK(a_valid_src, $rose(hash_valid) |-> ($past(state) == S_DONE), "result beat without final step")
  // an empty last chunk goes straight to finalization
  `ASSERT_CLK(a_empty_last, (accept && status.chunk_empty && last_chunk) |=> (state == S_FIN), "empty last chunk not finalized")
  // a chunk with data starts the mixing sequence
  `ASSERT_CLK(a_mix_start, (accept && !status.chunk_empty) |=> (state == S_M1_0), "chunk with data not mixed")
  // after the hash update the block either finalizes or waits for a chunk
  `ASSERT_CLK(a_seth_exit, (state == S_SETH) |=> (state == S_IDLE || state == S_FIN), "bad exit from hash update")

endmodule

`default_nettype wire

[hw/rtl/word_mix_hash64_unit.sv]
// Chunk with data: load, C1 multiply, mix into hash, C2 multiply, hash update;
// no new chunk beat is taken until the sequencer is idle again. A last chunk then goes on to
// finalization and the result beat; an empty last chunk goes there directly, an empty non-last one is ignored.
// Rate set by the single 32x32 multiplier: three passes per 64-bit multiply.
// Synchronous reset loads the seed, clears the byte total and drops hash_valid.
// ----------------------------------------------------------------------------
// word_mix_hash64_unit
// 64-bit multiply-xorshift hash over little-endian 8-byte chunk beats
// ----------------------------------------------------------------------------
`default_nettype none

module word_mix_hash64_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        chunk_valid,
  output logic             chunk_stall,
  input  wire logic [63:0] chunk_data,
  input  wire logic [3:0]  valid_bytes,
  input  wire logic        last_chunk,
  output logic             hash_valid,
  input  wire logic        hash_stall,
  output logic [63:0]      hash_value
);
  import wmh_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  wmh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .chunk_valid (chunk_valid),
    .chunk_stall (chunk_stall),
    .last_chunk  (last_chunk),
    .hash_valid  (hash_valid),
    .hash_stall  (hash_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // hash datapath
  wmh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .chunk_data  (chunk_data),
    .valid_bytes (valid_bytes),
    .hash_value  (hash_value)
  );

endmodule

`default_nettype wire
